>>> hw/rtl/modbus_reply_frame_channel_extractor_top_assert.svh
// Assertion macros for the frame extractor top level
`ifndef MODBUS_REPLY_FRAME_CHANNEL_EXTRACTOR_TOP_ASSERT_SVH
`define MODBUS_REPLY_FRAME_CHANNEL_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication
`define MRFCE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define MRFCE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> hw/rtl/mrfce_pkg.sv
`default_nettype none
package mrfce_pkg;
   localparam int DEF_MAX_CHANNELS = 8;
   localparam int RESULT_LIMIT     = 8;
   localparam int BYTE_W           = 8;
   localparam int WORD_W           = 32;
   localparam int INDEX_W          = 3;
   localparam int COUNT_W          = 4;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 8;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT   = 4'd8;
   localparam logic [BYTE_W-1:0]  RST_HEADER_ADDRESS  = 8'h01;
   localparam logic [BYTE_W-1:0]  RST_HEADER_FUNCTION = 8'h04;
   localparam logic [BYTE_W-1:0]  RST_HEADER_COUNT    = 8'h10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT   = 2'd0,
      CSR_HEADER_ADDRESS  = 2'd1,
      CSR_HEADER_FUNCTION = 2'd2,
      CSR_HEADER_COUNT    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_PAYLOAD = 4'b0010,
      PH_CRC_LO  = 4'b0100,
      PH_CRC_HI  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic               bank;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [1:0] busy;
      logic       wbank;
   } front_status_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/mrfce_req_if.sv
`default_nettype none
interface mrfce_req_if;
   import mrfce_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mrfce_rsp_if.sv
`default_nettype none
interface mrfce_rsp_if;
   import mrfce_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] channel_index;
   logic [WORD_W-1:0]  channel_word;
   logic               last_word;
   modport source (output valid, output channel_index, output channel_word,
                   output last_word, input ready);
   modport sink (input valid, input channel_index, input channel_word,
                 input last_word, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mrfce_front.sv
`default_nettype none
module mrfce_front #(
   parameter int MAX_CHANNELS = mrfce_pkg::DEF_MAX_CHANNELS,
   parameter int ADDR_W       = $clog2(2 * MAX_CHANNELS)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire mrfce_pkg::csr_index_type         csr_index,
   input  wire logic [mrfce_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                             in_valid,
   input  wire logic [mrfce_pkg::BYTE_W-1:0]     in_data,
   output logic                                  in_ready,
   output logic                                  wr_en,
   output logic [ADDR_W-1:0]                     wr_addr,
   output logic [mrfce_pkg::WORD_W-1:0]          wr_data,
   output logic                                  push,
   output mrfce_pkg::cmd_type                    push_cmd,
   input  wire mrfce_pkg::release_type           rel,
   output mrfce_pkg::front_status_type           fstat
);
   import mrfce_pkg::*;

   localparam int PAYLOAD_BYTES = 4 * MAX_CHANNELS;
   localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
   localparam int EMIT_LIMIT    = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]        crc_ff, crc_in, crc_fed, hdr_crc;
   logic [BYTE_W-1:0]  crc_lo_ff, crc_lo_in;
   logic [1:0]         busy_ff, busy_in;
   logic               wbank_ff, wbank_in;
   logic [BYTE_W-1:0]  b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [COUNT_W-1:0] cc_ff, cc_in, count_clip;
   logic [BYTE_W-1:0]  haddr_ff, haddr_in, hfunc_ff, hfunc_in, hcnt_ff, hcnt_in;
   logic               accept;

   assign in_ready = !(phase_ff == PH_PAYLOAD && busy_ff[wbank_ff]);
   assign accept   = in_valid && in_ready;

   assign count_clip = (cc_ff > COUNT_W'(EMIT_LIMIT)) ? COUNT_W'(EMIT_LIMIT) : cc_ff;

   // seed the frame CRC from the header as currently configured
   assign hdr_crc = crc_feed(crc_feed(crc_feed(CRC_INIT, haddr_ff), hfunc_ff), hcnt_ff);
   assign crc_fed = crc_feed(crc_ff, in_data);

   assign wr_addr  = ADDR_W'({1'b0, wbank_ff} * MAX_CHANNELS + pos_ff[POS_W-1:2]);
   assign wr_data  = {b2_ff, in_data, b0_ff, b1_ff};
   assign push_cmd = '{bank: wbank_ff, count: count_clip};
   assign fstat    = '{busy: busy_ff, wbank: wbank_ff};

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      wbank_in  = wbank_ff;
      b0_in     = b0_ff;
      b1_in     = b1_ff;
      b2_in     = b2_ff;
      wr_en     = 1'b0;
      push      = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (pos_ff == POS_W'(0)) begin
                  pos_in = (in_data == haddr_ff) ? POS_W'(1) : POS_W'(0);
               end else if (pos_ff == POS_W'(1)) begin
                  if (in_data == hfunc_ff) begin
                     pos_in = POS_W'(2);
                  end else begin
                     pos_in = (in_data == haddr_ff) ? POS_W'(1) : POS_W'(0);
                  end
               end else begin
                  if (in_data == hcnt_ff) begin
                     phase_in = PH_PAYLOAD;
                     pos_in   = '0;
                     crc_in   = hdr_crc;
                  end else if (hfunc_ff == haddr_ff && in_data == hfunc_ff) begin
                     pos_in = POS_W'(2);
                  end else begin
                     pos_in = (in_data == haddr_ff) ? POS_W'(1) : POS_W'(0);
                  end
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc_fed;
               case (pos_ff[1:0])
                  2'd0:    b0_in = in_data;
                  2'd1:    b1_in = in_data;
                  2'd2:    b2_in = in_data;
                  default: wr_en = 1'b1;
               endcase
               if (pos_ff == POS_W'(PAYLOAD_BYTES - 1)) begin
                  phase_in = PH_CRC_LO;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            PH_CRC_LO: begin
               crc_lo_in = in_data;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               if ({in_data, crc_lo_ff} == crc_ff && count_clip != '0) begin
                  push     = 1'b1;
                  wbank_in = !wbank_ff;
               end
               phase_in  = PH_HUNT;
               pos_in    = '0;
               crc_in    = CRC_INIT;
               crc_lo_in = '0;
            end
            default: begin
               phase_in = PH_HUNT;
               pos_in   = '0;
               crc_in   = CRC_INIT;
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (push) begin
         busy_in[wbank_ff] = 1'b1;
      end
   end

   always_comb begin
      cc_in    = cc_ff;
      haddr_in = haddr_ff;
      hfunc_in = hfunc_ff;
      hcnt_in  = hcnt_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_COUNT:   cc_in    = csr_wdata[COUNT_W-1:0];
            CSR_HEADER_ADDRESS:  haddr_in = csr_wdata;
            CSR_HEADER_FUNCTION: hfunc_in = csr_wdata;
            CSR_HEADER_COUNT:    hcnt_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         pos_ff    <= '0;
         crc_ff    <= CRC_INIT;
         crc_lo_ff <= '0;
         busy_ff   <= '0;
         wbank_ff  <= 1'b0;
         cc_ff     <= RST_CHANNEL_COUNT;
         haddr_ff  <= RST_HEADER_ADDRESS;
         hfunc_ff  <= RST_HEADER_FUNCTION;
         hcnt_ff   <= RST_HEADER_COUNT;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
         busy_ff   <= busy_in;
         wbank_ff  <= wbank_in;
         cc_ff     <= cc_in;
         haddr_ff  <= haddr_in;
         hfunc_ff  <= hfunc_in;
         hcnt_ff   <= hcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/mrfce_queue.sv
`default_nettype none
module mrfce_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire mrfce_pkg::cmd_type          push_cmd,
   input  wire logic                        pop,
   output mrfce_pkg::cmd_type               head,
   output mrfce_pkg::queue_status_type      status
);
   import mrfce_pkg::*;

   cmd_type    entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign head   = entry_ff[rd_ptr_ff];
   assign status = '{full: fill_ff == 2'd2, empty: fill_ff == 2'd0};

   always_comb begin
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/mrfce_back.sv
`default_nettype none
module mrfce_back #(
   parameter int MAX_CHANNELS = mrfce_pkg::DEF_MAX_CHANNELS,
   parameter int ADDR_W       = $clog2(2 * MAX_CHANNELS)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [mrfce_pkg::WORD_W-1:0]  wr_data,
   input  wire mrfce_pkg::cmd_type            head,
   input  wire mrfce_pkg::queue_status_type   qstat,
   output logic                               pop,
   output mrfce_pkg::release_type             rel,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [mrfce_pkg::INDEX_W-1:0]      out_index,
   output logic [mrfce_pkg::WORD_W-1:0]       out_word,
   output logic                               out_last
);
   import mrfce_pkg::*;

   localparam int DEPTH = 2 * MAX_CHANNELS;

   logic [WORD_W-1:0]  mem [DEPTH];
   logic [WORD_W-1:0]  rd_ff;
   logic [INDEX_W-1:0] h_ff, h_in, index_ff;
   logic               valid_ff, valid_in, last_ff;
   logic               advance, issue, last;
   logic [ADDR_W-1:0]  rd_addr;

   assign advance = !valid_ff || out_ready;
   assign issue   = advance && !qstat.empty;
   assign last    = ({1'b0, h_ff} + COUNT_W'(1)) == head.count;
   assign pop     = issue && last;
   assign rel     = '{valid: pop, bank: head.bank};
   assign rd_addr = ADDR_W'({1'b0, head.bank} * MAX_CHANNELS + h_ff);

   assign out_valid = valid_ff;
   assign out_index = index_ff;
   assign out_word  = rd_ff;
   assign out_last  = last_ff;

   always_comb begin
      valid_in = advance ? !qstat.empty : valid_ff;
      h_in     = h_ff;
      if (issue) begin
         h_in = last ? '0 : h_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         h_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         h_ff     <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_ff    <= mem[rd_addr];
         index_ff <= h_ff;
         last_ff  <= last;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/modbus_reply_frame_channel_extractor_top.sv
// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          data_byte[7:0]
// rsp_ch    out  valid/ready          channel_index[2:0], channel_word[31:0], last_word
// csr_*     in   csr_we, no wait      csr_index[1:0], csr_wdata[7:0]
// One byte is taken per cycle unless the input stalls; the CRC unit folds in one byte a cycle.
// Good frames' words leave a two-bank word memory, read port registered, one per ready cycle.
// The input stalls at payload start while its target bank still holds unsent words of a frame.
// Reset is synchronous and active high; no clearing pass is needed.
`default_nettype none
module modbus_reply_frame_channel_extractor_top #(
   parameter int MAX_CHANNELS = mrfce_pkg::DEF_MAX_CHANNELS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mrfce_req_if.sink                             req_ch,
   mrfce_rsp_if.source                           rsp_ch,
   input  wire logic                             csr_we,
   input  wire mrfce_pkg::csr_index_type         csr_index,
   input  wire logic [mrfce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mrfce_pkg::*;

   localparam int ADDR_W = $clog2(2 * MAX_CHANNELS);

   logic              wr_en, push, pop;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   cmd_type           push_cmd, head;
   release_type       rel;
   queue_status_type  q_status;
   front_status_type  fstat;

   mrfce_front #(.MAX_CHANNELS(MAX_CHANNELS), .ADDR_W(ADDR_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_ch.valid),
      .in_data   (req_ch.data_byte),
      .in_ready  (req_ch.ready),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_cmd  (push_cmd),
      .rel       (rel),
      .fstat     (fstat)
   );

   mrfce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   mrfce_back #(.MAX_CHANNELS(MAX_CHANNELS), .ADDR_W(ADDR_W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .head      (head),
      .qstat     (q_status),
      .pop       (pop),
      .rel       (rel),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_index (rsp_ch.channel_index),
      .out_word  (rsp_ch.channel_word),
      .out_last  (rsp_ch.last_word)
   );

`include "modbus_reply_frame_channel_extractor_top_assert.svh"

   `MRFCE_ASSERT_IMP(a_push_room, clock, reset, push, !q_status.full)
   `MRFCE_ASSERT_IMP(a_write_free_bank, clock, reset, wr_en, !fstat.busy[fstat.wbank])
   `MRFCE_ASSERT_NXT(a_words_in_order, clock, reset,
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_word,
      rsp_ch.valid && rsp_ch.channel_index == $past(rsp_ch.channel_index) + 3'd1)
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mrfce_pkg::*;

   localparam int MAX_CH        = DEF_MAX_CHANNELS;
   localparam int PAYLOAD_BYTES = 4 * MAX_CH;
   localparam int IDLE_PCT      = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int ITEM_TARGET   = 270;
   localparam int BURST_FRAMES  = 3;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [WORD_W-1:0]  word;
      logic               last_word;
   } channel_word_type;

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mrfce_req_if req_ch ();
   mrfce_rsp_if rsp_ch ();

   modbus_reply_frame_channel_extractor_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   logic [COUNT_W-1:0] cfg_channels;
   logic [BYTE_W-1:0]  cfg_address;
   logic [BYTE_W-1:0]  cfg_function;
   logic [BYTE_W-1:0]  cfg_count;

   // frame tracking state
   phase_type         link_phase;
   int                hdr_matched;
   int                payload_pos;
   logic [15:0]       crc_acc;
   logic [BYTE_W-1:0] crc_lo;
   logic [BYTE_W-1:0] frame_payload [PAYLOAD_BYTES];

   channel_word_type  pending_words [$];
   logic [BYTE_W-1:0] link_bytes [$];

   int req_offered     = 0;
   int req_accepted    = 0;
   int items_sent      = 0;
   int mismatches      = 0;
   int holds_asked     = 0;
   int holds_done      = 0;
   int hold_left       = 0;
   bit burst_mode      = 1'b0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [15:0] crc_add(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ 16'(b);
      repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
      return r;
   endfunction

   task automatic restart_hunt();
      link_phase  = PH_HUNT;
      hdr_matched = 0;
      payload_pos = 0;
      crc_acc     = CRC_INIT;
      crc_lo      = '0;
   endtask

   task automatic follow_link_byte(input logic [BYTE_W-1:0] b);
      channel_word_type w;
      int n;
      int base;
      case (link_phase)
         PH_HUNT: begin
            if (hdr_matched == 0) begin
               hdr_matched = (b == cfg_address) ? 1 : 0;
            end else if (hdr_matched == 1) begin
               if (b == cfg_function) hdr_matched = 2;
               else hdr_matched = (b == cfg_address) ? 1 : 0;
            end else if (b == cfg_count) begin
               crc_acc     = crc_add(crc_add(crc_add(CRC_INIT, cfg_address), cfg_function),
                                     cfg_count);
               link_phase  = PH_PAYLOAD;
               hdr_matched = 0;
               payload_pos = 0;
            end else if (cfg_function == cfg_address && b == cfg_function) begin
               hdr_matched = 2;
            end else begin
               hdr_matched = (b == cfg_address) ? 1 : 0;
            end
         end
         PH_PAYLOAD: begin
            frame_payload[payload_pos] = b;
            crc_acc = crc_add(crc_acc, b);
            payload_pos++;
            if (payload_pos == PAYLOAD_BYTES) begin
               link_phase  = PH_CRC_LO;
               payload_pos = 0;
            end
         end
         PH_CRC_LO: begin
            crc_lo     = b;
            link_phase = PH_CRC_HI;
         end
         default: begin
            if ({b, crc_lo} == crc_acc) begin
               n = int'(cfg_channels);
               if (n > MAX_CH) n = MAX_CH;
               if (n > RESULT_LIMIT) n = RESULT_LIMIT;
               for (int h = 0; h < n; h++) begin
                  base        = 4 * h;
                  w.index     = INDEX_W'(h);
                  w.word      = {frame_payload[base + 2], frame_payload[base + 3],
                                 frame_payload[base + 0], frame_payload[base + 1]};
                  w.last_word = (h == n - 1);
                  pending_words.push_back(w);
               end
            end
            restart_hunt();
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         follow_link_byte(req_ch.data_byte);
         req_accepted++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_accepted == req_offered) begin
         if (link_bytes.size() != 0 && (burst_mode || $urandom_range(99) >= IDLE_PCT)) begin
            req_ch.data_byte <= link_bytes.pop_front();
            req_ch.valid     <= 1'b1;
            req_offered++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (holds_done < holds_asked) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_done   <= holds_done + 1;
      end else begin
         rsp_ch.ready <= burst_mode || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      channel_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected transfer: channel_index %0d, channel_word %08h, last_word %0b",
                   rsp_ch.channel_index, rsp_ch.channel_word, rsp_ch.last_word);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_ch.channel_index !== want.index) begin
               $error("channel_index: expected %0d, actual %0d",
                      want.index, rsp_ch.channel_index);
               mismatches++;
            end
            if (rsp_ch.channel_word !== want.word) begin
               $error("channel_word: expected %08h, actual %08h",
                      want.word, rsp_ch.channel_word);
               mismatches++;
            end
            if (rsp_ch.last_word !== want.last_word) begin
               $error("last_word: expected %0b, actual %0b",
                      want.last_word, rsp_ch.last_word);
               mismatches++;
            end
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CHANNEL_COUNT:   cfg_channels = value[COUNT_W-1:0];
         CSR_HEADER_ADDRESS:  cfg_address  = value;
         CSR_HEADER_FUNCTION: cfg_function = value;
         default:             cfg_count    = value;
      endcase
   endtask

   task automatic apply_setting(input logic [3:0] channels, input logic [7:0] address,
                                input logic [7:0] func, input logic [7:0] count);
      write_csr(CSR_CHANNEL_COUNT, CSR_DATA_W'(channels));
      write_csr(CSR_HEADER_ADDRESS, address);
      write_csr(CSR_HEADER_FUNCTION, func);
      write_csr(CSR_HEADER_COUNT, count);
   endtask

   // drain every transfer, then flush any unfinished frame with filler
   task automatic wait_link_idle();
      do begin
         while (link_bytes.size() != 0 || req_accepted != req_offered
                || pending_words.size() != 0)
            @(negedge clock);
         if (link_phase != PH_HUNT) link_bytes.push_back(BYTE_W'($urandom_range(255)));
      end while (link_phase != PH_HUNT);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_frame(input bit crc_ok, input bit edge_values);
      logic [BYTE_W-1:0] body [$];
      logic [BYTE_W-1:0] v;
      logic [15:0]       crc;
      body = {cfg_address, cfg_function, cfg_count};
      crc  = crc_add(crc_add(crc_add(CRC_INIT, cfg_address), cfg_function), cfg_count);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         if (edge_values) begin
            case (i % 4)
               0:       v = 8'h00;
               1:       v = 8'hFF;
               2:       v = 8'h7F;
               default: v = 8'h80;
            endcase
         end else begin
            case ($urandom_range(9))
               0:       v = cfg_address;
               1:       v = cfg_count;
               2:       v = $urandom_range(1) ? 8'hFF : 8'h00;
               default: v = BYTE_W'($urandom_range(255));
            endcase
         end
         body.push_back(v);
         crc = crc_add(crc, v);
      end
      if (!crc_ok) crc ^= 16'($urandom_range(1, 16'hFFFF));
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      items_sent += body.size();
      link_bytes = {link_bytes, body};
   endtask

   task automatic push_random_unit();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         push_frame(1'b1, $urandom_range(9) == 0);
      end else if (pick < 75) begin
         push_frame(1'b0, 1'b0);
      end else if (pick < 87) begin
         link_bytes.push_back(cfg_address);
         if ($urandom_range(1)) link_bytes.push_back(cfg_function);
         link_bytes.push_back(BYTE_W'($urandom_range(255)));
         items_sent += 3;
      end else begin
         repeat ($urandom_range(1, 6)) link_bytes.push_back(BYTE_W'($urandom_range(255)));
      end
   endtask

   initial begin
      int phase_no;
      logic [7:0] address;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_CHANNEL_COUNT;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      cfg_channels     = RST_CHANNEL_COUNT;
      cfg_address      = RST_HEADER_ADDRESS;
      cfg_function     = RST_HEADER_FUNCTION;
      cfg_count        = RST_HEADER_COUNT;
      restart_hunt();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // wrong byte count, then a repeated address before a clean header
      link_bytes = {cfg_address, cfg_function, cfg_count ^ 8'h01, cfg_address,
                    8'h00, 8'hFF, cfg_address};
      items_sent += 7;
      push_frame(1'b1, 1'b1);
      wait_link_idle();

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase_no)
            0: apply_setting(4'd8, 8'h01, 8'h04, 8'h10);
            1: apply_setting(4'd15, 8'hFF, 8'h00, 8'hFF);
            2: apply_setting(4'd1, 8'h00, 8'h00, 8'h00);
            3: apply_setting(4'd0, 8'h55, 8'h55, 8'h00);
            default: begin
               address = BYTE_W'($urandom_range(255));
               apply_setting($urandom_range(3) == 0 ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(1, 8)),
                             address,
                             $urandom_range(3) == 0 ? address : BYTE_W'($urandom_range(255)),
                             BYTE_W'($urandom_range(255)));
            end
         endcase
         if (phase_no == 3) begin
            // address equals function: fall back onto the second header byte
            link_bytes = {8'h55, 8'h55, 8'h55};
            items_sent += 3;
         end
         if (phase_no == 0) begin
            // hold off the receiver while frames pour in back to back
            burst_mode = 1'b1;
            holds_asked++;
            repeat (BURST_FRAMES) push_frame(1'b1, 1'b0);
            wait_link_idle();
            burst_mode = 1'b0;
         end else begin
            repeat ($urandom_range(1, 2)) push_random_unit();
            wait_link_idle();
         end
         phase_no++;
      end

      wait_link_idle();
      if (mismatches == 0)
         $display("modbus_reply_frame_channel_extractor_top: match");
      else
         $display("modbus_reply_frame_channel_extractor_top: mismatch");
      $finish;
   end

   initial begin
      #2_400_000;
      $display("modbus_reply_frame_channel_extractor_top: mismatch");
      $finish;
   end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mrfce_pkg.sv
hw/rtl/mrfce_req_if.sv
hw/rtl/mrfce_rsp_if.sv
hw/rtl/mrfce_front.sv
hw/rtl/mrfce_queue.sv
hw/rtl/mrfce_back.sv
hw/rtl/modbus_reply_frame_channel_extractor_top.sv
tb/sv/tb_top.sv
